// ----- hdl/ppsr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppsr_pkg
// Shared command codes, status codes and the slot record layout.
// ----------------------------------------------------------------------------
package ppsr_pkg;

    localparam logic [2:0] CMD_OPEN    = 3'd0;
    localparam logic [2:0] CMD_REPLACE = 3'd1;
    localparam logic [2:0] CMD_CLOSE   = 3'd2;
    localparam logic [2:0] CMD_RELEASE = 3'd3;
    localparam logic [2:0] CMD_SNAP    = 3'd4;
    localparam logic [2:0] CMD_OWNCNT  = 3'd5;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_ERROR     = 2'd3;

    localparam logic [63:0] GEN_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic        active;
        logic [31:0] owner;
        logic [63:0] gen;
        logic [63:0] lsn;
    } slot_rec_t;

endpackage

// ----- hdl/page_pin_slot_registry_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_pin_slot_registry_unit
// Pin slot table in one synchronous memory, served by a scanning sequencer.
// ----------------------------------------------------------------------------
// Flow: replace and close access the named slot alone; open, snapshot and owner
//   count scan the table, and release may scan it twice.
// Throughput: one command in work at a time; scans read one slot per cycle, and
//   a stalled result holds the next command in its last step.
// Reset: synchronous, active low; a clearing pass then writes all TABLE_SLOTS
//   entries before the first transfer is taken.
module page_pin_slot_registry_unit
    import ppsr_pkg::*;
#(
    parameter int TABLE_SLOTS = 64
) (
    input  logic         aclk,
    input  logic         aresetn,
    // fields low to high: command[2:0], owner[34:3], slot idx[40:35],
    // expected gen[104:41], pin position[168:105]
    input  logic [175:0] s_tdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // fields low to high: status[1:0], result_slot[7:2],
    // result_generation[71:8], result_count[78:72], oldest_lsn[142:79]
    output logic [143:0] m_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    input  logic         cfg_we,
    input  logic [6:0]   cfg_wdata
);

    localparam int AW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CW = $clog2(TABLE_SLOTS + 1);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_DISPATCH, S_SCAN, S_SINGLE, S_FINISH
    } state_t;

    // Slot memory: one record per slot, registered read.
    slot_rec_t mem [TABLE_SLOTS];
    slot_rec_t mem_rd_reg;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    slot_rec_t     wr_data;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            mem_rd_reg <= mem[rd_addr];
        end
    end

    state_t        state_reg, state_next;
    logic [2:0]    cmd_reg, cmd_next;
    logic [31:0]   owner_reg, owner_next;
    logic [5:0]    idx_reg, idx_next;
    logic [63:0]   gen_reg, gen_next;
    logic [63:0]   lsn_reg, lsn_next;
    logic [CW-1:0] iss_reg, iss_next;
    logic          ev_valid_reg, ev_valid_next;
    logic [AW-1:0] ev_addr_reg, ev_addr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [63:0]   oldest_reg, oldest_next;
    logic          skip_reg, skip_next;
    logic          pass2_reg, pass2_next;
    logic [63:0]   tg_reg, tg_next;
    logic [6:0]    siu_reg;
    logic [CW-1:0] clr_reg, clr_next;
    logic [1:0]    res_status_reg, res_status_next;
    logic [5:0]    res_slot_reg, res_slot_next;
    logic [63:0]   res_gen_reg, res_gen_next;
    logic          m_valid_reg, m_valid_next;
    logic [143:0]  m_data_reg, m_data_next;

    logic [CW-1:0] n_slots;
    logic          idx_in_range;
    logic          rec_mine;
    logic          excluded;
    logic [6:0]    cnt_sat;

    assign n_slots = (32'(siu_reg) > 32'(TABLE_SLOTS)) ? CW'(TABLE_SLOTS) : CW'(siu_reg);
    assign idx_in_range = 32'(idx_reg) < 32'(n_slots);
    assign rec_mine = mem_rd_reg.active && (mem_rd_reg.owner == owner_reg);
    assign excluded = (gen_reg != 64'd0) && (32'(ev_addr_reg) == 32'(idx_reg))
                      && (mem_rd_reg.owner == owner_reg) && (mem_rd_reg.gen == gen_reg);
    assign cnt_sat = (32'(cnt_reg) > 32'd127) ? 7'd127 : 7'(cnt_reg);

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_comb begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        owner_next      = owner_reg;
        idx_next        = idx_reg;
        gen_next        = gen_reg;
        lsn_next        = lsn_reg;
        iss_next        = iss_reg;
        ev_valid_next   = 1'b0;
        ev_addr_next    = ev_addr_reg;
        cnt_next        = cnt_reg;
        oldest_next     = oldest_reg;
        skip_next       = skip_reg;
        pass2_next      = pass2_reg;
        tg_next         = tg_reg;
        clr_next        = clr_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_gen_next    = res_gen_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        rd_en           = 1'b0;
        rd_addr         = iss_reg[AW-1:0];
        wr_en           = 1'b0;
        wr_addr         = ev_addr_reg;
        wr_data         = '0;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR: begin
                // wipe one entry per cycle
                wr_en    = 1'b1;
                wr_addr  = clr_reg[AW-1:0];
                clr_next = clr_reg + 1'b1;
                if (32'(clr_reg) == 32'(TABLE_SLOTS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd_next   = s_tdata[2:0];
                    owner_next = s_tdata[34:3];
                    idx_next   = s_tdata[40:35];
                    gen_next   = s_tdata[104:41];
                    lsn_next   = s_tdata[168:105];
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                // check arguments, then start a scan or a single slot access
                res_status_next = ST_ERROR;
                res_slot_next   = '0;
                res_gen_next    = '0;
                cnt_next        = '0;
                oldest_next     = '0;
                skip_next       = 1'b0;
                pass2_next      = 1'b0;
                iss_next        = '0;
                state_next      = S_FINISH;
                case (cmd_reg)
                    CMD_OPEN: begin
                        if (owner_reg != 32'd0 && lsn_reg != 64'd0 && tg_reg != GEN_MAX) begin
                            state_next = S_SCAN;
                        end
                    end
                    CMD_REPLACE, CMD_CLOSE: begin
                        if (owner_reg != 32'd0 && gen_reg != 64'd0
                            && (lsn_reg != 64'd0 || cmd_reg == CMD_CLOSE)) begin
                            res_status_next = ST_NOT_FOUND;
                            if (idx_in_range) begin
                                rd_en      = 1'b1;
                                rd_addr    = AW'(idx_reg);
                                state_next = S_SINGLE;
                            end
                        end
                    end
                    CMD_RELEASE, CMD_OWNCNT: begin
                        if (owner_reg != 32'd0) begin
                            state_next = S_SCAN;
                        end
                    end
                    CMD_SNAP: begin
                        if (gen_reg == 64'd0 || owner_reg != 32'd0) begin
                            state_next = S_SCAN;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_SINGLE: begin
                wr_addr = AW'(idx_reg);
                if (mem_rd_reg.active && mem_rd_reg.owner == owner_reg
                    && mem_rd_reg.gen == gen_reg) begin
                    if (cmd_reg == CMD_REPLACE) begin
                        if (gen_reg == GEN_MAX || tg_reg == GEN_MAX) begin
                            res_status_next = ST_ERROR;
                        end else begin
                            wr_en           = 1'b1;
                            wr_data         = '{1'b1, mem_rd_reg.owner, gen_reg + 64'd1, lsn_reg};
                            tg_next         = tg_reg + 64'd1;
                            res_status_next = ST_OK;
                            res_slot_next   = idx_reg;
                            res_gen_next    = gen_reg + 64'd1;
                        end
                    end else begin
                        if (tg_reg == GEN_MAX) begin
                            res_status_next = ST_ERROR;
                        end else begin
                            wr_en           = 1'b1;
                            wr_data         = '{1'b0, 32'd0, mem_rd_reg.gen, 64'd0};
                            tg_next         = tg_reg + 64'd1;
                            res_status_next = ST_OK;
                        end
                    end
                end
                state_next = S_FINISH;
            end
            S_SCAN: begin
                // issue one read per cycle, evaluate the previous one
                if (iss_reg < n_slots) begin
                    rd_en         = 1'b1;
                    iss_next      = iss_reg + 1'b1;
                    ev_valid_next = 1'b1;
                    ev_addr_next  = iss_reg[AW-1:0];
                end
                if (ev_valid_reg) begin
                    case (cmd_reg)
                        CMD_OPEN: begin
                            if (!mem_rd_reg.active) begin
                                if (mem_rd_reg.gen == GEN_MAX) begin
                                    skip_next = 1'b1;
                                end else begin
                                    wr_en   = 1'b1;
                                    wr_data = '{1'b1, owner_reg, mem_rd_reg.gen + 64'd1,
                                                lsn_reg};
                                    tg_next         = tg_reg + 64'd1;
                                    res_status_next = ST_OK;
                                    res_slot_next   = 6'(ev_addr_reg);
                                    res_gen_next    = mem_rd_reg.gen + 64'd1;
                                    state_next      = S_FINISH;
                                end
                            end
                        end
                        CMD_RELEASE: begin
                            if (rec_mine) begin
                                if (pass2_reg) begin
                                    wr_en   = 1'b1;
                                    wr_data = '{1'b0, 32'd0, mem_rd_reg.gen, 64'd0};
                                end else begin
                                    cnt_next = cnt_reg + 1'b1;
                                end
                            end
                        end
                        CMD_SNAP: begin
                            if (mem_rd_reg.active && !excluded && mem_rd_reg.lsn != 64'd0) begin
                                cnt_next = cnt_reg + 1'b1;
                                if (oldest_reg == 64'd0 || mem_rd_reg.lsn < oldest_reg) begin
                                    oldest_next = mem_rd_reg.lsn;
                                end
                            end
                        end
                        default: begin
                            if (rec_mine) begin
                                cnt_next = cnt_reg + 1'b1;
                            end
                        end
                    endcase
                end else if (!(iss_reg < n_slots)) begin
                    // scan drained
                    state_next      = S_FINISH;
                    res_status_next = ST_OK;
                    case (cmd_reg)
                        CMD_OPEN: begin
                            res_status_next = skip_reg ? ST_ERROR : ST_FULL;
                        end
                        CMD_RELEASE: begin
                            if (pass2_reg) begin
                                tg_next = tg_reg + 64'(cnt_reg);
                            end else if (64'(cnt_reg) > ~tg_reg) begin
                                res_status_next = ST_ERROR;
                                cnt_next        = '0;
                            end else if (cnt_reg != '0) begin
                                pass2_next = 1'b1;
                                iss_next   = '0;
                                state_next = S_SCAN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_FINISH: begin
                // hold until the result register is free
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {1'b0, oldest_reg, cnt_sat, res_gen_reg,
                                    res_slot_reg, res_status_reg};
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_reg      <= '0;
            tg_reg       <= '0;
            siu_reg      <= 7'd64;
            m_valid_reg  <= 1'b0;
            ev_valid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            tg_reg       <= tg_next;
            m_valid_reg  <= m_valid_next;
            ev_valid_reg <= ev_valid_next;
            if (cfg_we) begin
                siu_reg <= cfg_wdata;
            end
        end
        cmd_reg        <= cmd_next;
        owner_reg      <= owner_next;
        idx_reg        <= idx_next;
        gen_reg        <= gen_next;
        lsn_reg        <= lsn_next;
        iss_reg        <= iss_next;
        ev_addr_reg    <= ev_addr_next;
        cnt_reg        <= cnt_next;
        oldest_reg     <= oldest_next;
        skip_reg       <= skip_next;
        pass2_reg      <= pass2_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_gen_reg    <= res_gen_next;
        m_data_reg     <= m_data_next;
    end

endmodule

// ----- hdl/ppsr_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppsr_checker
// Port-level checks for the pin slot registry, bound to the top level.
// ----------------------------------------------------------------------------
module ppsr_checker
    import ppsr_pkg::*;
(
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [143:0] m_tdata
);

    // a stalled result transfer holds its data
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one command at a time: input closes after a transfer
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while busy");

    // any status but ok carries zero fields
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1:0] != ST_OK |-> m_tdata[142:2] == '0)
        else $error("non-ok result has nonzero fields");

    // a granted generation comes only with ok and no count or position
    a_grant: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[71:8] != 64'd0
        |-> m_tdata[1:0] == ST_OK && m_tdata[142:72] == '0)
        else $error("grant result mixes fields");

endmodule

bind page_pin_slot_registry_unit ppsr_checker u_ppsr_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
